>>> hdl/sidta_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; every other file of the block imports this package.
package sidta_pkg;

   // Width of the magnitude after sign removal (2**31 still fits unsigned)
   localparam int MAG_W         = 32;
   // Decimal digits of the largest magnitude and width of one BCD digit
   localparam int NUM_DIGITS    = 10;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int IDX_W         = 4;
   // Binary bits folded into the BCD register per conversion cycle
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = MAG_W / BITS_PER_STEP;
   localparam int STEP_W        = 3;

   // Output character codes
   localparam logic [5:0] CHAR_MINUS = 6'd45;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   // One classified input: sign flag and unsigned magnitude
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } item_type;

   // One converted number: sign, BCD digits, index of the leading digit
   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] digits;
      logic [IDX_W-1:0] top;
   } bcd_type;

endpackage

>>> hdl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Request channel (req_valid, req_stall, req_value): one two's complement integer per beat.
// Response channel (rsp_valid, rsp_stall, rsp_char_code, rsp_last_char): the text, one
// character per beat, most significant first: '-' for negative values, then the digits
// without leading zeros ('0' alone for zero). rsp_last_char marks the final character.
// Structure: input register -> item queue -> BCD converter -> character emitter.
// Each number gives 1 to 11 characters. The converter folds four magnitude bits per
// cycle; the emitter loads a number, then sends one character per cycle while
// rsp_stall is low.
// The converter works on the next number while the emitter sends the current one.
// Reset (synchronous, active high) empties every stage; no response is pending after it.
// A stalled response holds its character; the queue and input register absorb up to
// QUEUE_DEPTH + 1 numbers before req_stall rises.
// Depends on sidta_pkg and the sidta_* submodules.
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_char_code,
   output logic        rsp_last_char
);
   import sidta_pkg::*;

   logic     push, pop, q_empty, q_full;
   item_type push_data, pop_data;
   logic     cv_valid, cv_take;
   bcd_type  cv_data;

   sidta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   sidta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   sidta_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .pop       (pop),
      .pop_data  (pop_data),
      .out_valid (cv_valid),
      .out_data  (cv_data),
      .out_take  (cv_take)
   );

   sidta_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cv_valid),
      .in_data       (cv_data),
      .in_take       (cv_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> hdl/sidta_front.sv
// Input stage: accepts one integer per beat and splits it into sign and magnitude.
// Depends on sidta_pkg for item_type.
module sidta_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_value,
   output logic                push,
   output sidta_pkg::item_type push_data,
   input  logic                q_full
);
   import sidta_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // Stall only while the held item cannot move into the queue
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_full;
   assign push_data = item_ff;

   // Classify the incoming value: sign bit and two's complement magnitude
   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.neg = req_value[31];
         item_in.mag = req_value[31] ? (32'd0 - req_value) : req_value;
      end
   end

   // Hold the item until it is pushed; a new beat may replace it the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> hdl/sidta_queue.sv
// Short queue of classified items between the input stage and the converter.
// Depends on sidta_pkg for item_type.
module sidta_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sidta_pkg::item_type push_data,
   input  logic                pop,
   output sidta_pkg::item_type pop_data,
   output logic                empty,
   output logic                full
);
   import sidta_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/sidta_conv.sv
// Binary to BCD converter: shift-and-add-3, several bits per cycle.
// Depends on sidta_pkg for item_type, bcd_type and the digit constants.
module sidta_conv (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                pop,
   input  sidta_pkg::item_type pop_data,
   output logic                out_valid,
   output sidta_pkg::bcd_type  out_data,
   input  logic                out_take
);
   import sidta_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [MAG_W-1:0]  bin_v;
   logic [BCD_W-1:0]  bcd_v;
   logic [IDX_W-1:0]  top;

   // Start a new conversion only with both the unit and its result slot free
   assign pop = !busy_ff && !done_ff && !q_empty;

   // Fold the next group of binary bits into the BCD digits
   always_comb begin
      bcd_v = bcd_ff;
      bin_v = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_v[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               bcd_v[d*DIGIT_W +: DIGIT_W] = bcd_v[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         {bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
      end
   end

   // Sequence load, steps and handoff
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (pop) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = pop_data.neg;
         bin_in  = pop_data.mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bin_in  = bin_v;
         bcd_in  = bcd_v;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && out_take) begin
         done_in = 1'b0;
      end
   end

   // Locate the leading nonzero digit; zero keeps the units digit
   always_comb begin
      top = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != 4'd0) begin
            top = IDX_W'(d);
         end
      end
   end

   assign out_valid       = done_ff;
   assign out_data.neg    = neg_ff;
   assign out_data.digits = bcd_ff;
   assign out_data.top    = top;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

>>> hdl/sidta_emit.sv
// Character emitter: sends the sign and the digits, leading digit first, one per beat.
// Depends on sidta_pkg for bcd_type and the character codes.
module sidta_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sidta_pkg::bcd_type in_data,
   output logic               in_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_char_code,
   output logic               rsp_last_char
);
   import sidta_pkg::*;

   logic               busy_ff, busy_in;
   logic               sign_ff, sign_in;
   logic [BCD_W-1:0]   digits_ff, digits_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         code_ff, code_in;
   logic               last_ff, last_in;
   logic               advance;
   logic [DIGIT_W-1:0] digit;

   assign in_take = !busy_ff && in_valid;
   assign advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign digit   = digits_ff[{pos_ff, 2'b00} +: DIGIT_W];

   // Load a number, then move one character per beat into the output register
   always_comb begin
      busy_in      = busy_ff;
      sign_in      = sign_ff;
      digits_in    = digits_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      if (in_take) begin
         busy_in   = 1'b1;
         sign_in   = in_data.neg;
         digits_in = in_data.digits;
         pos_in    = in_data.top;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (sign_ff) begin
            code_in = CHAR_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            code_in = CHAR_ZERO + {2'b00, digit};
            last_in = (pos_ff == IDX_W'(0));
            if (pos_ff == IDX_W'(0)) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff - IDX_W'(1);
            end
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last_char = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff   <= sign_in;
      digits_ff <= digits_in;
      pos_ff    <= pos_in;
      code_ff   <= code_in;
      last_ff   <= last_in;
   end

endmodule

>>> hdl/sidta_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, attached by the bind below.
// Depends on sidta_pkg for the character codes.
module sidta_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_char_code,
   input logic       rsp_last_char
);
   import sidta_pkg::*;

   // Drop any pending response on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response beat
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code)
                                 && $stable(rsp_last_char))
      else $error("stalled response changed");

   // Emit only the minus sign or a digit
   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_code == CHAR_MINUS
                    || (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_ZERO + 6'd9))
      else $error("illegal character code");

   // Never end a run on the sign
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_MINUS |-> !rsp_last_char)
      else $error("minus sign marked last");

   // Follow a sign with a nonzero leading digit
   a_no_minus_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_char_code == CHAR_MINUS
      ##1 rsp_valid && !rsp_stall |-> rsp_char_code != CHAR_ZERO)
      else $error("leading zero after minus sign");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char)
);

>>> tb/sv/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_decimal_ascii: integers in, decimal text out.
// Needs sidta_pkg for the character codes and digit count; drives random idling on both sides.
module signed_int_to_decimal_ascii_tb;
   import sidta_pkg::*;

   localparam logic [32:0] RADIX        = 33'd10;
   localparam int          WATCHDOG_MAX = 2000;
   localparam int          HOLD_AT      = 60;
   localparam int          HOLD_CYCLES  = 120;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          RANDOM_ITEMS = 100;
   localparam int          MAX_REPORTS  = 10;

   // One character of expected text
   typedef struct {
      logic [5:0] code;
      logic       last;
   } text_char_type;

   // One integer waiting to be offered, with the idle cycles that follow it
   typedef struct {
      logic [31:0] value;
      int unsigned gap_after;
      bit          drain;
   } pending_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_char_code;
   logic        rsp_last_char;

   pending_type   backlog[$];
   text_char_type text_due[$];
   int unsigned gap_left   = 0;
   int unsigned chars_owed = 0;
   int unsigned beats_in   = 0;
   int unsigned chars_out  = 0;
   int unsigned text_errors = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   int unsigned idle_cycles = 0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Spell one integer as decimal text and append it to the expected characters
   function automatic void spell_value(input logic [31:0] value);
      logic        neg;
      logic [32:0] mag;
      logic [3:0]  digit [0:NUM_DIGITS-1];
      int          n;
      neg = value[31];
      // 33-bit magnitude keeps the most negative value intact
      mag = neg ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
      n = 0;
      do begin
         digit[n] = 4'(mag % RADIX);
         mag = mag / RADIX;
         n++;
      end while (mag != 0 && n < NUM_DIGITS);
      if (neg)
         text_due.push_back('{code: CHAR_MINUS, last: 1'b0});
      for (int k = n - 1; k >= 0; k--)
         text_due.push_back('{code: CHAR_ZERO + 6'(digit[k]), last: (k == 0)});
   endfunction

   // Count a failure, print only the first few
   function automatic void flag_error(input string msg);
      text_errors++;
      if (text_errors <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Random integer with a random digit count, so short and long texts both occur
   function automatic logic [31:0] pick_value();
      int unsigned n_digits;
      int unsigned lo_mag;
      int unsigned hi_mag;
      int unsigned mag;
      bit          neg;
      n_digits = $urandom_range(1, NUM_DIGITS);
      neg = 1'($urandom_range(0, 1));
      lo_mag = 1;
      repeat (n_digits - 1) lo_mag = lo_mag * 10;
      if (n_digits == NUM_DIGITS)
         hi_mag = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else
         hi_mag = lo_mag * 10 - 1;
      if (n_digits == 1)
         lo_mag = 0;
      mag = $urandom_range(hi_mag, lo_mag);
      return neg ? -mag : mag;
   endfunction

   task automatic queue_value(input logic [31:0] value, input int unsigned gap,
                              input bit drain);
      backlog.push_back('{value: value, gap_after: gap, drain: drain});
   endtask

   // Offer queued integers; hold a stalled beat, idle between beats
   always @(posedge clock) begin : drive_values
      pending_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         gap_left  <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (backlog.size() != 0 &&
                      (!backlog[0].drain || (!req_valid && chars_owed == 0))) begin
            nxt = backlog.pop_front();
            req_valid <= 1'b1;
            req_value <= nxt.value;
            gap_left  <= nxt.gap_after;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random wait per character, one long hold-off mid-run
   always @(posedge clock) begin : drive_stall
      int unsigned wait_draw;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         // a stretch of characters with no receiver idling every so often
         wait_draw  = ((chars_out % 256) < 64) ? 0 : $urandom_range(0, 11);
         rsp_stall  <= (wait_draw != 0);
         stall_left <= (wait_draw != 0) ? wait_draw - 1 : 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each accepted integer, check each accepted character
   always @(posedge clock) begin : check_text
      text_char_type due;
      if (reset) begin
         beats_in   <= 0;
         chars_out  <= 0;
         chars_owed <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            spell_value(req_value);
            beats_in <= beats_in + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            chars_out <= chars_out + 1;
            if (text_due.size() == 0) begin
               flag_error($sformatf("unexpected character code %0d last %0b",
                                    rsp_char_code, rsp_last_char));
            end else begin
               due = text_due.pop_front();
               if (rsp_char_code !== due.code || rsp_last_char !== due.last)
                  flag_error($sformatf(
                     "character %0d: expected code %0d last %0b, got code %0d last %0b",
                     chars_out, due.code, due.last, rsp_char_code, rsp_last_char));
            end
         end
         chars_owed <= text_due.size();
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no beat for %0d cycles", idle_cycles);
         $display("** signed_int_to_decimal_ascii: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Fill the backlog, release reset, wait for the text to drain, report
   initial begin : run_test
      logic [31:0] directed [] = '{
         0, 1, -1, 5, 9, 10, -9, -10, 99, 100, -100,
         999999999, 1000000000, -999999999, -1000000000,
         2147483647, -2147483647, 32'h8000_0000,
         32'h5555_5555, 32'hAAAA_AAAA, 123456789, -123456789
      };
      logic [31:0] value;
      bit          burst;

      // directed corners: zero, single digits, digit-count boundaries, extremes
      foreach (directed[i])
         queue_value(directed[i], $urandom_range(0, 11), 1'b0);

      // random part; sender pauses for a full drain twice, bursts without gaps
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         value = ($urandom_range(0, 3) == 0) ? $urandom : pick_value();
         burst = (i >= 25 && i < 70) || (i >= 88 && i < 98);
         queue_value(value, burst ? 0 : $urandom_range(0, 11), (i == 0 || i == 80));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (backlog.size() != 0 || req_valid || chars_owed != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (text_due.size() != 0)
         flag_error($sformatf("%0d characters never arrived", text_due.size()));

      $display("Converted %0d integers into %0d characters with random idling,",
               beats_in, chars_out);
      $display("a %0d-cycle output hold-off and drained pauses; %0d errors.",
               HOLD_CYCLES, text_errors);
      if (text_errors == 0)
         $display("** signed_int_to_decimal_ascii: PASSED **");
      else
         $display("** signed_int_to_decimal_ascii: FAILED **");
      $finish;
   end

endmodule
